### src/qkb_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// qkb_pkg
// Shared types and constants for the quadrature knob with push button.
// ============================================================================
package qkb_pkg;

    localparam int POSITION_WIDTH_DEFAULT = 8;
    localparam int POS_OUT_W              = 8;
    localparam int LOCK_W                 = 8;

    localparam logic [LOCK_W-1:0] LOCKOUT_LIMIT_RESET = 8'd100;
    localparam logic [LOCK_W-1:0] LOCK_TICKS_MAX      = 8'hFF;

    typedef logic [1:0] qkb_code_t;

    // next phase code for a step up and a step down, indexed by current code
    localparam qkb_code_t NEXT_UP   [4] = '{2'h2, 2'h0, 2'h3, 2'h1};
    localparam qkb_code_t NEXT_DOWN [4] = '{2'h1, 2'h3, 2'h0, 2'h2};

    typedef struct packed {
        logic push;
        logic release_evt;
        logic held;
    } qkb_btn_evt_t;

endpackage

### src/qkb_button.sv
`timescale 1ns / 1ps
// ============================================================================
// qkb_button
// Button press/release state machine with lockout counter and held flag.
// ============================================================================
module qkb_button (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      step_en,
    input  logic                      pressed,
    input  logic [qkb_pkg::LOCK_W-1:0] lockout_limit,
    output qkb_pkg::qkb_btn_evt_t     evt
);
    import qkb_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE         = 2'd0,
        PH_PRESSED      = 2'd1,
        PH_PRESS_LOCK   = 2'd2,
        PH_RELEASE_LOCK = 2'd3
    } phase_t;

    phase_t            phase_reg, phase_next, phase_cur;
    logic [LOCK_W-1:0] ticks_reg, ticks_next, ticks_inc;
    logic              held_reg, held_next;
    logic              push, rel;

    assign ticks_inc = (ticks_reg == LOCK_TICKS_MAX) ? ticks_reg : ticks_reg + 1'b1;

    always_comb begin
        phase_cur  = phase_reg;
        phase_next = phase_reg;
        ticks_next = ticks_reg;
        held_next  = held_reg;
        push       = 1'b0;
        rel        = 1'b0;
        if (pressed && phase_reg == PH_IDLE) begin
            phase_cur = PH_PRESSED;
        end
        unique case (phase_cur)
            PH_IDLE: begin
                phase_next = PH_IDLE;
            end
            PH_PRESSED: begin
                push       = 1'b1;
                phase_next = PH_PRESS_LOCK;
            end
            PH_PRESS_LOCK: begin
                if (!held_reg) begin
                    ticks_next = ticks_inc;
                end
                if (ticks_next > lockout_limit) begin
                    ticks_next = '0;
                    held_next  = 1'b1;
                end
                if (held_next && !pressed) begin
                    phase_next = PH_RELEASE_LOCK;
                end
            end
            PH_RELEASE_LOCK: begin
                rel = (ticks_reg == '0);
                if (held_reg) begin
                    ticks_next = ticks_inc;
                end
                if (ticks_next > lockout_limit) begin
                    ticks_next = '0;
                    held_next  = 1'b0;
                    phase_next = PH_IDLE;
                end
            end
        endcase
    end

    assign evt.push        = push;
    assign evt.release_evt = rel;
    assign evt.held        = held_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            ticks_reg <= '0;
            held_reg  <= 1'b0;
        end else if (step_en) begin
            phase_reg <= phase_next;
            ticks_reg <= ticks_next;
            held_reg  <= held_next;
        end
    end

endmodule

### src/quadrature_knob_with_button.sv
`timescale 1ns / 1ps
// ============================================================================
// quadrature_knob_with_button
// x4 quadrature position counter with debounced push button events.
// ============================================================================
//
//  channel  direction  handshake            beat
//  s_       in         s_valid / s_ready    phase_a, phase_b, button_level
//  m_       out        m_valid / m_ready    position, push/release, lockout
//  cfg_     in         cfg_valid/cfg_ready  lockout_limit
//
//  one beat per cycle while m_ready keeps up; an s_ accept reaches m_valid through the
//  input register, one pass of decode and button logic, then the result register
//  aresetn clears position, phase history, button state; limit resets to 100
//  a stalled m_ side holds the result; s_ready stays high while the
//  input register can move forward or is empty
//
module quadrature_knob_with_button #(
    parameter int POSITION_WIDTH = qkb_pkg::POSITION_WIDTH_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_phase_a,
    input  logic                          s_phase_b,
    input  logic                          s_button_level,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [qkb_pkg::POS_OUT_W-1:0] m_position,
    output logic                          m_push_event,
    output logic                          m_release_event,
    output logic                          m_lockout_active,

    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [qkb_pkg::LOCK_W-1:0]    cfg_data
);
    import qkb_pkg::*;

    logic                      in_valid_reg;
    qkb_code_t                 in_code_reg;
    logic                      in_button_reg;

    logic [LOCK_W-1:0]         limit_reg;
    qkb_code_t                 last_code_reg;
    logic [POSITION_WIDTH-1:0] position_reg, position_next;

    logic                      out_valid_reg;
    logic [POS_OUT_W-1:0]      out_position_reg;
    logic                      out_push_reg, out_release_reg, out_held_reg;

    logic                      out_free, step_en;
    qkb_btn_evt_t              btn_evt;

    assign out_free  = !out_valid_reg || m_ready;
    assign step_en   = in_valid_reg && out_free;
    assign s_ready   = !in_valid_reg || out_free;
    assign cfg_ready = 1'b1;

    always_comb begin
        position_next = position_reg;
        if (in_code_reg == NEXT_UP[last_code_reg]) begin
            position_next = position_reg + 1'b1;
        end else if (in_code_reg == NEXT_DOWN[last_code_reg]) begin
            position_next = position_reg - 1'b1;
        end
    end

    qkb_button u_button (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step_en       (step_en),
        .pressed       (!in_button_reg),
        .lockout_limit (limit_reg),
        .evt           (btn_evt)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            limit_reg     <= LOCKOUT_LIMIT_RESET;
            last_code_reg <= '0;
            position_reg  <= '0;
        end else begin
            if (cfg_valid) begin
                limit_reg <= cfg_data;
            end
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (step_en) begin
                last_code_reg <= in_code_reg;
                position_reg  <= position_next;
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_code_reg   <= {s_phase_b, s_phase_a};
            in_button_reg <= s_button_level;
        end
        if (step_en) begin
            out_position_reg <= POS_OUT_W'(position_next);
            out_push_reg     <= btn_evt.push;
            out_release_reg  <= btn_evt.release_evt;
            out_held_reg     <= btn_evt.held;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_position       = out_position_reg;
    assign m_push_event     = out_push_reg;
    assign m_release_event  = out_release_reg;
    assign m_lockout_active = out_held_reg;

endmodule

### bench/quadrature_knob_with_button_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// quadrature_knob_with_button_tb
// Self-checking bench for the quadrature knob with push button. Sample ticks
// carry encoder phases and the button pin; an in-bench decoder and debounce
// tracker predicts every result beat, and a monitor compares it field by field.
// Covers Gray steps both ways, wrap, double steps, lockout limits from 0 to
// 255 with counter saturation, random idle bursts and a long sink stall.
// ============================================================================
module quadrature_knob_with_button_tb;

    import qkb_pkg::*;

    typedef enum logic [1:0] {
        BTN_IDLE,
        BTN_PRESSED,
        BTN_PRESS_LOCK,
        BTN_RELEASE_LOCK
    } btn_state_t;

    typedef struct packed {
        logic [POS_OUT_W-1:0] position;
        logic                 push;
        logic                 release_evt;
        logic                 held;
    } knob_result_t;

    localparam int HOLD_OFF_CYCLES = 250;
    localparam int MAX_REPORTS     = 50;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_phase_a;
    logic                  s_phase_b;
    logic                  s_button_level;
    logic                  m_valid;
    logic                  m_ready;
    logic [POS_OUT_W-1:0]  m_position;
    logic                  m_push_event;
    logic                  m_release_event;
    logic                  m_lockout_active;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [LOCK_W-1:0]     cfg_data;

    // decoder and debounce state mirrored in the bench
    qkb_code_t             knob_phases = '0;
    logic [POS_OUT_W-1:0]  knob_pos    = '0;
    btn_state_t            btn_state   = BTN_IDLE;
    logic [LOCK_W-1:0]     lock_ticks  = '0;
    logic                  held_flag   = 1'b0;
    logic [LOCK_W-1:0]     limit_reg   = LOCKOUT_LIMIT_RESET;

    knob_result_t          tick_results[$];
    qkb_code_t             stim_code = '0;

    bit                    gaps_on   = 1'b1;
    bit                    stalls_on = 1'b1;
    bit                    hold_req  = 1'b0;

    int                    mismatches     = 0;
    int                    ticks_sent     = 0;
    int                    ticks_checked  = 0;
    int                    pushes_seen    = 0;
    int                    releases_seen  = 0;

    quadrature_knob_with_button dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_phase_a        (s_phase_a),
        .s_phase_b        (s_phase_b),
        .s_button_level   (s_button_level),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_position       (m_position),
        .m_push_event     (m_push_event),
        .m_release_event  (m_release_event),
        .m_lockout_active (m_lockout_active),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #(5_000_000);
        $display("watchdog expired at %0t with %0d results outstanding",
                 $time, tick_results.size());
        $display("Simulation FAILED");
        $finish;
    end

    // x4 decode plus press/release lockout tracking for one sample tick
    function automatic knob_result_t decode_tick(input logic a, input logic b,
                                                 input logic btn);
        qkb_code_t    code;
        logic         pressed;
        knob_result_t res;
        code    = {b, a};
        pressed = ~btn;
        res     = '0;
        case ({knob_phases, code})
            {2'd0, 2'd2}, {2'd2, 2'd3}, {2'd3, 2'd1}, {2'd1, 2'd0}:
                knob_pos = knob_pos + 1'b1;
            {2'd2, 2'd0}, {2'd3, 2'd2}, {2'd1, 2'd3}, {2'd0, 2'd1}:
                knob_pos = knob_pos - 1'b1;
            default: ;
        endcase
        knob_phases = code;

        if (pressed && btn_state == BTN_IDLE) btn_state = BTN_PRESSED;
        case (btn_state)
            BTN_PRESSED: begin
                res.push  = 1'b1;
                btn_state = BTN_PRESS_LOCK;
            end
            BTN_PRESS_LOCK: begin
                if (!held_flag && lock_ticks != LOCK_TICKS_MAX) lock_ticks++;
                if (lock_ticks > limit_reg) begin
                    lock_ticks = '0;
                    held_flag  = 1'b1;
                end
                if (held_flag && !pressed) btn_state = BTN_RELEASE_LOCK;
            end
            BTN_RELEASE_LOCK: begin
                if (lock_ticks == '0) res.release_evt = 1'b1;
                if (held_flag && lock_ticks != LOCK_TICKS_MAX) lock_ticks++;
                if (lock_ticks > limit_reg) begin
                    lock_ticks = '0;
                    held_flag  = 1'b0;
                    btn_state  = BTN_IDLE;
                end
            end
            default: ;
        endcase
        res.position = knob_pos;
        res.held     = held_flag;
        return res;
    endfunction

    // next code along the Gray sequence 00,10,11,01 (b,a packed as {b,a})
    function automatic qkb_code_t knob_move(input qkb_code_t c, input bit up);
        case (c)
            2'd0:    return up ? 2'd2 : 2'd1;
            2'd2:    return up ? 2'd3 : 2'd0;
            2'd3:    return up ? 2'd1 : 2'd2;
            default: return up ? 2'd0 : 2'd3;
        endcase
    endfunction

    task automatic send_tick(input logic a, input logic b, input logic btn);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_phase_a      <= a;
        s_phase_b      <= b;
        s_button_level <= btn;
        do @(posedge aclk); while (!s_ready);
        tick_results.push_back(decode_tick(a, b, btn));
        stim_code = {b, a};
        ticks_sent++;
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (tick_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_lockout_limit(input logic [LOCK_W-1:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        limit_reg = value;
    endtask

    // knob walk with press/release runs of random length and short bounces
    task automatic drive_knob_session(input int n, input int run_lo,
                                      input int run_hi);
        int   run_left;
        int   up_pct;
        int   r;
        logic btn;
        btn      = 1'b1;
        run_left = $urandom_range(1, 4);
        up_pct   = $urandom_range(15, 85);
        for (int i = 0; i < n; i++) begin
            if (run_left == 0) begin
                btn      = ~btn;
                run_left = $urandom_range(run_lo, run_hi);
            end
            run_left--;
            r = $urandom_range(0, 99);
            if (r < 80) begin
                stim_code = knob_move(stim_code, $urandom_range(0, 99) < up_pct);
            end else if (r < 94) begin
                stim_code = stim_code;
            end else if (r < 97) begin
                stim_code = stim_code ^ 2'b11;
            end else begin
                stim_code = qkb_code_t'($urandom_range(0, 3));
            end
            send_tick(stim_code[0], stim_code[1],
                      ($urandom_range(0, 11) == 0) ? ~btn : btn);
        end
    endtask

    task automatic check_field(input string name, input int unsigned expv,
                               input int unsigned actv);
        if (expv != actv) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, expv, actv);
        end
    endtask

    always @(posedge aclk) begin : check_results
        knob_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (tick_results.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected beat, expected none, actual pos %0d %b%b%b",
                         $time, m_position, m_push_event, m_release_event,
                         m_lockout_active);
            end else begin
                want = tick_results.pop_front();
                check_field("position", 32'(want.position), 32'(m_position));
                check_field("push_event", 32'(want.push), 32'(m_push_event));
                check_field("release_event", 32'(want.release_evt),
                            32'(m_release_event));
                check_field("lockout_active", 32'(want.held),
                            32'(m_lockout_active));
                ticks_checked++;
                if (want.push) pushes_seen++;
                if (want.release_evt) releases_seen++;
            end
        end
    end

    // sink side: random stall bursts, plus one long hold-off on request
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
                m_ready <= 1'b1;
            end else if (stalls_on && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic test_phase_steps();
        // up through all four codes, then down back and one step past zero
        send_tick(1'b0, 1'b1, 1'b1);
        send_tick(1'b1, 1'b1, 1'b1);
        send_tick(1'b1, 1'b0, 1'b1);
        send_tick(1'b0, 1'b0, 1'b1);
        send_tick(1'b1, 1'b0, 1'b1);
        send_tick(1'b1, 1'b1, 1'b1);
        send_tick(1'b0, 1'b1, 1'b1);
        send_tick(1'b0, 1'b0, 1'b1);
        send_tick(1'b1, 1'b0, 1'b1);
        // no change, then both phases flip at once
        send_tick(1'b1, 1'b0, 1'b1);
        send_tick(1'b0, 1'b1, 1'b1);
    endtask

    task automatic test_default_limit();
        // reset limit of 100 before any register write
        drive_knob_session(240, 100, 115);
    endtask

    task automatic test_button_directed();
        set_lockout_limit(8'd0);
        send_tick(1'b0, 1'b0, 1'b0);
        // press lockout ends on this tick; the release event comes with the press tick below
        send_tick(1'b0, 1'b0, 1'b1);
        // press while in release lockout is ignored
        send_tick(1'b0, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b1);
        send_tick(1'b0, 1'b0, 1'b1);

        set_lockout_limit(8'd255);
        send_tick(1'b0, 1'b1, 1'b0);
        send_tick(1'b1, 1'b1, 1'b1);
        send_tick(1'b1, 1'b1, 1'b1);
        send_tick(1'b1, 1'b1, 1'b1);
        // lowering the limit lets the stuck lockout finish
        set_lockout_limit(8'd2);
        send_tick(1'b1, 1'b0, 1'b1);
        send_tick(1'b1, 1'b0, 1'b1);
        send_tick(1'b0, 1'b0, 1'b1);
        send_tick(1'b0, 1'b0, 1'b1);
    endtask

    task automatic test_counter_saturation();
        set_lockout_limit(8'd255);
        send_tick(stim_code[0], stim_code[1], 1'b0);
        drive_knob_session(290, 1, 6);
        set_lockout_limit(8'd254);
        drive_knob_session(300, 250, 270);
    endtask

    task automatic test_random_sessions();
        for (int k = 0; k < 6; k++) begin
            gaps_on   = $urandom_range(0, 3) != 0;
            stalls_on = $urandom_range(0, 3) != 0;
            set_lockout_limit((k == 0) ? 8'd0 : 8'($urandom_range(1, 12)));
            drive_knob_session(110, 1, int'(limit_reg) + 6);
        end
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
    endtask

    task automatic test_sink_hold_off();
        gaps_on  = 1'b0;
        hold_req = 1'b1;
        drive_knob_session(40, 1, 8);
        gaps_on  = 1'b1;
    endtask

    task automatic test_steady_stream();
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        set_lockout_limit(8'($urandom_range(0, 5)));
        drive_knob_session(100, 1, int'(limit_reg) + 6);
    endtask

    initial begin
        aresetn        <= 1'b0;
        s_valid        <= 1'b0;
        s_phase_a      <= 1'b0;
        s_phase_b      <= 1'b0;
        s_button_level <= 1'b1;
        cfg_valid      <= 1'b0;
        cfg_data       <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        test_phase_steps();
        test_default_limit();
        test_button_directed();
        test_counter_saturation();
        test_random_sessions();
        test_sink_hold_off();
        test_steady_stream();

        wait_idle();
        repeat (10) @(posedge aclk);
        $display("%0d ticks sent, %0d beats checked, %0d push and %0d release events",
                 ticks_sent, ticks_checked, pushes_seen, releases_seen);
        $display("lockout limits 0 to 255 with saturation, idle bursts and a long sink stall");
        if (mismatches == 0 && tick_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

### sim.f
src/qkb_pkg.sv
src/qkb_button.sv
src/quadrature_knob_with_button.sv
bench/quadrature_knob_with_button_tb.sv
